// ----- sv/assert_macros.svh -----
// Assertion macros used by the qualifier core.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every enabled clock edge.
`define ABHQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define ABHQ_ASSERT_IMP(label, ante, cons, msg) \
    `ABHQ_ASSERT(label, (ante) |-> (cons), msg)

// Antecedent in this cycle implies consequent in the next cycle.
`define ABHQ_ASSERT_NEXT(label, ante, cons, msg) \
    `ABHQ_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ----- sv/abhq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abhq_pkg
// Types and constants of the analog button hysteresis qualifier.
// ----------------------------------------------------------------------------
package abhq_pkg;

    localparam int unsigned SLOT_COUNT    = 16;
    localparam int unsigned BUTTON_COUNT  = 16;
    localparam int unsigned BUTTON_STRIDE = 16;
    localparam int unsigned HOLD_DEPTH    = SLOT_COUNT * BUTTON_STRIDE;
    localparam int unsigned HOLD_AW       = $clog2(HOLD_DEPTH);
    localparam int unsigned SLOT_AW       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 64;

    localparam logic [7:0] HOLD_RESET = 8'hFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEVEL_THRESHOLD = 3'd0,
        REG_BUTTON_ENABLE   = 3'd1,
        REG_SLOT_ACTIVE     = 3'd2,
        REG_MARGINS_LOW     = 3'd3,
        REG_MARGINS_HIGH    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [3:0] slot_index;
        logic [3:0] button_index;
        logic [7:0] new_level;
        logic [7:0] current_level;
    } sample_word_t;

    typedef struct packed {
        logic [15:0] slot_pressed_bits;
        logic        button_pressed;
        logic [7:0]  hold_level;
        logic        skipped;
    } result_word_t;

    typedef struct packed {
        logic [8:0]  level_threshold;
        logic [15:0] button_enable_mask;
        logic [15:0] slot_active_mask;
        logic [63:0] margins_low;
        logic [63:0] margins_high;
    } cfg_t;

    // Write-back of one evaluated word into the state stores.
    typedef struct packed {
        logic        en;
        logic [3:0]  slot_index;
        logic [3:0]  button_index;
        logic [7:0]  hold;
        logic [15:0] flags;
    } store_wr_t;

endpackage

// ----- sv/abhq_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abhq_cfg_regs
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
module abhq_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [abhq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [abhq_pkg::CFG_DATA_W-1:0]     cfg_data,
    output abhq_pkg::cfg_t                      cfg
);
    import abhq_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEVEL_THRESHOLD: cfg_next.level_threshold    = cfg_data[8:0];
                REG_BUTTON_ENABLE:   cfg_next.button_enable_mask = cfg_data[15:0];
                REG_SLOT_ACTIVE:     cfg_next.slot_active_mask   = cfg_data[15:0];
                REG_MARGINS_LOW:     cfg_next.margins_low        = cfg_data;
                REG_MARGINS_HIGH:    cfg_next.margins_high       = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/abhq_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abhq_store
// Hold-level memory with per-entry valid bits, and the per-slot pressed bits.
// ----------------------------------------------------------------------------
module abhq_store (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rd_en,
    input  logic [3:0]              rd_slot,
    input  logic [3:0]              rd_button,
    input  logic [3:0]              cur_slot,
    input  logic [3:0]              cur_button,
    input  abhq_pkg::store_wr_t     wr,
    output logic [7:0]              hold_level,
    output logic [15:0]             slot_flags
);
    import abhq_pkg::*;

    logic [7:0]         hold_mem [HOLD_DEPTH];
    logic [7:0]         rd_data_reg;
    logic [7:0]         byp_data_reg;
    logic               byp_reg;
    logic               hold_valid_reg [HOLD_DEPTH];
    logic [15:0]        pressed_reg [SLOT_COUNT];
    logic [HOLD_AW-1:0] rd_idx;
    logic [HOLD_AW-1:0] wr_idx;
    logic [HOLD_AW-1:0] cur_idx;
    logic [SLOT_AW-1:0] wr_slot;
    logic [SLOT_AW-1:0] cur_slot_idx;

    assign rd_idx       = HOLD_AW'({rd_slot, rd_button});
    assign wr_idx       = HOLD_AW'({wr.slot_index, wr.button_index});
    assign cur_idx      = HOLD_AW'({cur_slot, cur_button});
    assign wr_slot      = SLOT_AW'(wr.slot_index);
    assign cur_slot_idx = SLOT_AW'(cur_slot);

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            hold_mem[wr_idx] <= wr.hold;
        end
        if (rd_en)
        begin
            rd_data_reg  <= hold_mem[rd_idx];
            byp_data_reg <= wr.hold;
        end
    end

    // The memory reads the old entry when the word ahead writes it in the
    // same cycle, so that write is carried forward here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
            for (int i = 0; i < HOLD_DEPTH; i++)
            begin
                hold_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                pressed_reg[i] <= '0;
            end
        end
        else
        begin
            if (rd_en)
            begin
                byp_reg <= wr.en && (wr_idx == rd_idx);
            end
            if (wr.en)
            begin
                hold_valid_reg[wr_idx] <= 1'b1;
                pressed_reg[wr_slot]   <= wr.flags;
            end
        end
    end

    always_comb
    begin
        if (!hold_valid_reg[cur_idx])
        begin
            hold_level = HOLD_RESET;
        end
        else if (byp_reg)
        begin
            hold_level = byp_data_reg;
        end
        else
        begin
            hold_level = rd_data_reg;
        end
    end

    assign slot_flags = pressed_reg[cur_slot_idx];

endmodule

// ----- sv/abhq_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abhq_eval
// Hysteresis decision for one button word: hold, pressed bit and result.
// ----------------------------------------------------------------------------
module abhq_eval (
    input  abhq_pkg::sample_word_t  word,
    input  abhq_pkg::cfg_t          cfg,
    input  logic [7:0]              hold_stored,
    input  logic [15:0]             flags_stored,
    output logic                    skip,
    output logic [7:0]              hold_new,
    output logic [15:0]             flags_new,
    output abhq_pkg::result_word_t  result
);
    import abhq_pkg::*;

    logic         slot_ok;
    logic         button_ok;
    logic [127:0] margins;
    logic [7:0]   margin;
    logic [15:0]  bit_mask;
    logic [7:0]   hold_min;
    logic [8:0]   cur_plus_m;
    logic [8:0]   hold_plus_m;

    assign slot_ok   = 32'(word.slot_index) < 32'(SLOT_COUNT);
    assign button_ok = 32'(word.button_index) < 32'(BUTTON_COUNT);
    assign skip      = !slot_ok || !button_ok
                       || !cfg.slot_active_mask[word.slot_index]
                       || !cfg.button_enable_mask[word.button_index];

    assign margins  = {cfg.margins_high, cfg.margins_low};
    assign margin   = margins[{word.button_index, 3'b000} +: 8];
    assign bit_mask = 16'(1) << word.button_index;

    assign hold_min    = (word.current_level < hold_stored) ? word.current_level : hold_stored;
    // The signed test cur < new - m is the same as cur + m < new without wrap.
    assign cur_plus_m  = {1'b0, word.current_level} + {1'b0, margin};
    assign hold_plus_m = {1'b0, hold_min} + {1'b0, margin};

    always_comb
    begin
        hold_new  = hold_min;
        flags_new = flags_stored;
        if ({1'b0, word.current_level} >= cfg.level_threshold)
        begin
            if (cur_plus_m < {1'b0, word.new_level})
            begin
                flags_new = flags_stored & ~bit_mask;
                hold_new  = word.current_level;
            end
            else if (hold_min != 8'd0)
            begin
                if (hold_plus_m < {1'b0, word.current_level})
                begin
                    flags_new = flags_stored | bit_mask;
                    hold_new  = 8'd0;
                end
                else
                begin
                    flags_new = flags_stored & ~bit_mask;
                end
            end
        end
    end

    always_comb
    begin
        result.skipped = skip;
        if (!slot_ok)
        begin
            result.slot_pressed_bits = '0;
            result.button_pressed    = 1'b0;
            result.hold_level        = '0;
        end
        else if (skip)
        begin
            result.slot_pressed_bits = flags_stored;
            result.button_pressed    = flags_stored[word.button_index];
            result.hold_level        = hold_stored;
        end
        else
        begin
            result.slot_pressed_bits = flags_new;
            result.button_pressed    = flags_new[word.button_index];
            result.hold_level        = hold_new;
        end
    end

endmodule

// ----- sv/analog_button_hysteresis_qualifier_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_button_hysteresis_qualifier_core
// Turns analog button levels into pressed bits with per-button hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   Sample words (slot, button, new level, current level) enter on the
//   sample channel; one result word per sample leaves on the result channel.
//   A word moves when its valid is high and its stall is low.
//   The sample edge registers the word and reads the hold memory; the word is
//   then evaluated and, when the result register can take it, written back to
//   the stores and loaded into the result register. Throughput is one word per
//   cycle unless the receiver stalls; the hold memory read and write-back loop
//   is closed by forwarding, so back-to-back words to one button work.
//   When the receiver stalls, the result register holds its word, one more
//   sample is taken into the input register, and then sample_stall rises.
//   Reset clears both channels, the configuration and the pressed bits and
//   marks all hold entries unwritten, so they read as 255 with no clearing pass.
//   The user writes configuration only while idle; the block does not check it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module analog_button_hysteresis_qualifier_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_stall,
    input  abhq_pkg::sample_word_t            sample_word,
    output logic                              result_valid,
    input  logic                              result_stall,
    output abhq_pkg::result_word_t            result_word,
    input  logic                              cfg_we,
    input  logic [abhq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [abhq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import abhq_pkg::*;

    cfg_t         cfg;
    logic         s1_valid_reg;
    logic         s1_valid_next;
    sample_word_t s1_word_reg;
    logic         result_valid_reg;
    logic         result_valid_next;
    result_word_t result_word_reg;
    logic         sample_take;
    logic         s1_adv;
    logic [7:0]   hold_stored;
    logic [15:0]  flags_stored;
    logic         skip;
    logic [7:0]   hold_new;
    logic [15:0]  flags_new;
    result_word_t eval_result;
    store_wr_t    wr;

    abhq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    abhq_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (sample_take),
        .rd_slot    (sample_word.slot_index),
        .rd_button  (sample_word.button_index),
        .cur_slot   (s1_word_reg.slot_index),
        .cur_button (s1_word_reg.button_index),
        .wr         (wr),
        .hold_level (hold_stored),
        .slot_flags (flags_stored)
    );

    abhq_eval u_eval (
        .word         (s1_word_reg),
        .cfg          (cfg),
        .hold_stored  (hold_stored),
        .flags_stored (flags_stored),
        .skip         (skip),
        .hold_new     (hold_new),
        .flags_new    (flags_new),
        .result       (eval_result)
    );

    assign s1_adv       = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !s1_adv;
    assign sample_take  = sample_valid && !sample_stall;

    assign wr.en           = s1_adv && !skip;
    assign wr.slot_index   = s1_word_reg.slot_index;
    assign wr.button_index = s1_word_reg.button_index;
    assign wr.hold         = hold_new;
    assign wr.flags        = flags_new;

    always_comb
    begin
        s1_valid_next     = sample_take || (s1_valid_reg && !s1_adv);
        result_valid_next = s1_adv || (result_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            s1_word_reg <= sample_word;
        end
        if (s1_adv)
        begin
            result_word_reg <= eval_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    `ABHQ_ASSERT_IMP(a_stall_only_when_full, sample_stall,
        s1_valid_reg && result_valid_reg && result_stall,
        "sample stalled while the pipeline has room")
    `ABHQ_ASSERT_NEXT(a_adv_loads_result, s1_adv, result_valid_reg,
        "evaluated word did not reach the result register")
    `ABHQ_ASSERT_IMP(a_pressed_means_hold_zero,
        result_valid_reg && result_word_reg.button_pressed,
        result_word_reg.hold_level == 8'd0,
        "pressed button reported with a nonzero hold level")

endmodule
